>>> rtl/ectm_pkg.sv
// ectm_pkg: shared types, keyword table and codes of the error text category matcher
// used by ectm_front, ectm_queue, ectm_back and error_text_category_matcher_unit
package ectm_pkg;

  localparam int KEY_COUNT   = 28;
  localparam int KEY_MAX_LEN = 16;
  localparam int GROUP_COUNT = 6;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [KEY_MAX_LEN*8-1:0] key_text_t;

  // text right-justified: last character in the low byte
  localparam key_text_t KEY_TEXT [KEY_COUNT] = '{
    "connection", "timeout", "unreachable", "network", "dns",
    "permission", "access denied", "unauthorized", "forbidden", "authentication",
    "config", "invalid resource", "not found", "does not exist", "missing",
    "memory", "disk", "space", "quota", "limit",
    "syntax", "parse", "invalid", "format",
    "build", "compile", "dependency", "package"
  };

  localparam logic [4:0] KEY_LEN [KEY_COUNT] = '{
    5'd10, 5'd7, 5'd11, 5'd7, 5'd3,
    5'd10, 5'd13, 5'd12, 5'd9, 5'd14,
    5'd6, 5'd16, 5'd9, 5'd14, 5'd7,
    5'd6, 5'd4, 5'd5, 5'd5, 5'd5,
    5'd6, 5'd5, 5'd7, 5'd6,
    5'd5, 5'd7, 5'd10, 5'd7
  };

  localparam logic [2:0] KEY_GROUP [KEY_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5
  };

  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_LINT  = 3'd1,
    KIND_TYPE  = 3'd2,
    KIND_BUILD = 3'd3,
    KIND_TEST  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CAT_NETWORK    = 3'd0,
    CAT_PERMISSION = 3'd1,
    CAT_CONFIG     = 3'd2,
    CAT_RESOURCE   = 3'd3,
    CAT_SYNTAX     = 3'd4,
    CAT_BUILD      = 3'd5,
    CAT_TEST_LOGIC = 3'd6,
    CAT_UNKNOWN    = 3'd7
  } cat_t;

  // one finished message handed from front to back
  typedef struct packed {
    kind_t                  kind;
    logic [GROUP_COUNT-1:0] groups;
  } msg_entry_t;

  function automatic key_text_t key_mask(input logic [4:0] len);
    key_text_t m;
    m = '0;
    for (int i = 0; i < KEY_MAX_LEN; i++) begin
      if (i < int'(len)) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

>>> rtl/ectm_front.sv
// ectm_front: lowercases bytes, keeps the byte window and sticky keyword hits,
// and emits one summary per message; depends on ectm_pkg
module ectm_front import ectm_pkg::*; #(
  parameter int WINDOW_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // message_byte
  input  logic       s_axis_tlast,   // end_of_message
  input  logic [3:0] s_axis_tuser,   // byte_present, event_kind
  input  logic       push_ready,
  output logic       push,
  output msg_entry_t push_entry
);

  logic [WINDOW_BYTES-2:0][7:0] hist;
  logic [KEY_COUNT-1:0]         hits;
  logic [KEY_COUNT-1:0]         match;
  logic [KEY_COUNT-1:0]         hits_next;
  logic [KEY_MAX_LEN-1:0][7:0]  window;
  logic [7:0]                   cur;
  logic                         present;
  logic                         accept;
  logic [2:0]                   kind_raw;

  assign present       = s_axis_tuser[0];
  assign kind_raw      = s_axis_tuser[3:1];
  assign s_axis_tready = push_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && s_axis_tlast;

  assign cur    = (s_axis_tdata inside {[8'h41:8'h5a]}) ? s_axis_tdata + 8'd32 : s_axis_tdata;
  assign window = {hist[KEY_MAX_LEN-2:0], cur};

  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      match[k] = ((window ^ KEY_TEXT[k]) & key_mask(KEY_LEN[k])) == '0;
    end
    hits_next = present ? (hits | match) : hits;
  end

  always_comb begin
    push_entry.groups = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (hits_next[k]) push_entry.groups[KEY_GROUP[k]] = 1'b1;
    end
    push_entry.kind = (kind_raw inside {[3'd0:3'd4]}) ? kind_t'(kind_raw) : KIND_OTHER;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
      hits <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        hist <= '0;
        hits <= '0;
      end else if (present) begin
        hist <= {hist[WINDOW_BYTES-3:0], cur};
        hits <= hits_next;
      end
    end
  end

  a_clear_on_end: assert property (@(posedge clk) disable iff (rst)
    push |=> (hits == '0 && hist == '0))
    else $error("window or hits not cleared after end of message");

endmodule

>>> rtl/ectm_queue.sv
// ectm_queue: short fifo of message summaries between front and back
// depends on ectm_pkg
module ectm_queue import ectm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  msg_entry_t push_entry,
  output logic       push_ready,
  input  logic       pop,
  output logic       pop_valid,
  output msg_entry_t pop_entry
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  msg_entry_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W:0]         count;

  assign push_ready = count != (PTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

>>> rtl/ectm_back.sv
// ectm_back: turns a message summary into a category by fixed priority
// and holds it in the output register; depends on ectm_pkg
module ectm_back import ectm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  input  msg_entry_t pop_entry,
  output logic       pop,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // category
);

  cat_t category;
  cat_t cat_next;

  always_comb begin
    if (pop_entry.groups[0])      cat_next = CAT_NETWORK;
    else if (pop_entry.groups[1]) cat_next = CAT_PERMISSION;
    else if (pop_entry.groups[2]) cat_next = CAT_CONFIG;
    else if (pop_entry.groups[3]) cat_next = CAT_RESOURCE;
    else if (pop_entry.groups[4] || pop_entry.kind == KIND_LINT || pop_entry.kind == KIND_TYPE)
      cat_next = CAT_SYNTAX;
    else if (pop_entry.groups[5] || pop_entry.kind == KIND_BUILD)
      cat_next = CAT_BUILD;
    else if (pop_entry.kind == KIND_TEST)
      cat_next = CAT_TEST_LOGIC;
    else
      cat_next = CAT_UNKNOWN;
  end

  assign pop          = pop_valid && (!m_axis_tvalid || m_axis_tready);
  assign m_axis_tdata = {5'd0, category};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) category <= cat_next;
  end

endmodule

>>> rtl/error_text_category_matcher_unit.sv
// error_text_category_matcher_unit: top level of the error text category matcher
// an end-of-message summary is queued, then its category goes into the output register
// one request per cycle unless the queue is full; window keyword compare is combinational
// a two-entry summary queue lets input and output stall independently
// reset (rst, synchronous): window and hits cleared, queue and output emptied
// depends on ectm_pkg, ectm_front, ectm_queue, ectm_back
module error_text_category_matcher_unit import ectm_pkg::*; #(
  parameter int WINDOW_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // message_byte
  input  logic       s_axis_tlast,   // end_of_message
  input  logic [3:0] s_axis_tuser,   // byte_present, event_kind[2:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // category[2:0], zero fill
);

  logic       push;
  logic       push_ready;
  msg_entry_t push_entry;
  logic       pop;
  logic       pop_valid;
  msg_entry_t pop_entry;

  ectm_front #(.WINDOW_BYTES(WINDOW_BYTES)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .push_ready    (push_ready),
    .push          (push),
    .push_entry    (push_entry)
  );

  ectm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  ectm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> tb/tb_error_text_category_matcher_unit.sv
// tb_error_text_category_matcher_unit: self-checking bench for the error text category matcher
// streams directed and random messages, predicts each category and checks every result in order
// depends on ectm_pkg and error_text_category_matcher_unit
`timescale 1ns / 1ps

module tb_error_text_category_matcher_unit import ectm_pkg::*;;

  localparam int WIN = 16;
  localparam int RANDOM_REQS = 1300;

  typedef struct {
    logic [7:0] data;
    bit         present;
    bit         last;
    logic [2:0] kind;
    int         gap;
    bit         hold;
  } msg_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;   // message_byte
  logic       s_axis_tlast = 1'b0; // end_of_message
  logic [3:0] s_axis_tuser = '0;   // byte_present, event_kind[2:0]
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // category[2:0], zero fill

  error_text_category_matcher_unit #(.WINDOW_BYTES(WIN)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  string kw_text [KEY_COUNT] = '{
    "connection", "timeout", "unreachable", "network", "dns",
    "permission", "access denied", "unauthorized", "forbidden", "authentication",
    "config", "invalid resource", "not found", "does not exist", "missing",
    "memory", "disk", "space", "quota", "limit",
    "syntax", "parse", "invalid", "format",
    "build", "compile", "dependency", "package"
  };

  cat_t kw_cat [KEY_COUNT] = '{
    CAT_NETWORK, CAT_NETWORK, CAT_NETWORK, CAT_NETWORK, CAT_NETWORK,
    CAT_PERMISSION, CAT_PERMISSION, CAT_PERMISSION, CAT_PERMISSION, CAT_PERMISSION,
    CAT_CONFIG, CAT_CONFIG, CAT_CONFIG, CAT_CONFIG, CAT_CONFIG,
    CAT_RESOURCE, CAT_RESOURCE, CAT_RESOURCE, CAT_RESOURCE, CAT_RESOURCE,
    CAT_SYNTAX, CAT_SYNTAX, CAT_SYNTAX, CAT_SYNTAX,
    CAT_BUILD, CAT_BUILD, CAT_BUILD, CAT_BUILD
  };

  logic [7:0]          recent [WIN-1];
  logic [KEY_COUNT-1:0] hit_flags;

  msg_item_t pend [$];
  cat_t      category_q [$];

  bit   in_taken = 1'b0;
  bit   out_taken = 1'b0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  bit   hold_next = 1'b0;
  int   n_planned = 0;
  int   n_req = 0;
  int   n_msg = 0;
  int   n_err = 0;
  logic [7:0] cat_seen = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // message predictor: lowercase, shift window, sticky keyword hits, priority decision
  task automatic predict_category(input logic [7:0] raw, input bit present, input bit last,
                                  input logic [2:0] kind, output bit has_cat, output cat_t cat);
    logic [7:0]             win [WIN];
    logic [7:0]             lc;
    logic [GROUP_COUNT-1:0] groups;
    kind_t                  kd;
    bit                     ok;
    int                     len;
    has_cat = 1'b0;
    cat = CAT_UNKNOWN;
    if (present) begin
      lc = (raw >= "A" && raw <= "Z") ? raw + 8'd32 : raw;
      for (int i = 0; i < WIN - 1; i++) win[i] = recent[i];
      win[WIN-1] = lc;
      for (int k = 0; k < KEY_COUNT; k++) begin
        len = kw_text[k].len();
        ok = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (win[WIN-len+i] != kw_text[k][i]) ok = 1'b0;
        end
        if (ok) hit_flags[k] = 1'b1;
      end
      for (int i = 0; i < WIN - 1; i++) recent[i] = win[i+1];
    end
    if (last) begin
      groups = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
        if (hit_flags[k]) groups[kw_cat[k]] = 1'b1;
      end
      kd = (kind > KIND_TEST) ? KIND_OTHER : kind_t'(kind);
      if (groups[CAT_NETWORK]) cat = CAT_NETWORK;
      else if (groups[CAT_PERMISSION]) cat = CAT_PERMISSION;
      else if (groups[CAT_CONFIG]) cat = CAT_CONFIG;
      else if (groups[CAT_RESOURCE]) cat = CAT_RESOURCE;
      else if (groups[CAT_SYNTAX] || kd == KIND_LINT || kd == KIND_TYPE) cat = CAT_SYNTAX;
      else if (groups[CAT_BUILD] || kd == KIND_BUILD) cat = CAT_BUILD;
      else if (kd == KIND_TEST) cat = CAT_TEST_LOGIC;
      else cat = CAT_UNKNOWN;
      has_cat = 1'b1;
      for (int i = 0; i < WIN - 1; i++) recent[i] = '0;
      hit_flags = '0;
    end
  endtask

  task automatic put(input logic [7:0] d, input bit p, input bit l, input logic [2:0] k);
    msg_item_t it;
    it.data = d;
    it.present = p;
    it.last = l;
    it.kind = k;
    it.gap = tx_calm ? 0 : $urandom_range(0, 14);
    it.hold = hold_next;
    hold_next = 1'b0;
    pend.push_back(it);
    if (p || l) n_planned++;
  endtask

  function automatic logic [7:0] pick_filler();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) return " ";
    return 8'($urandom_range(97, 122));
  endfunction

  // stimulus
  initial begin
    logic [7:0] txt [$];
    logic [7:0] ch;
    string      word;
    string      caps;
    int         style;
    int         cut;
    int         bad;
    bit         tail;
    logic [2:0] kind;

    for (int i = 0; i < WIN - 1; i++) recent[i] = '0;
    hit_flags = '0;

    // empty messages with every event kind, known and unknown
    for (int k = 0; k < 8; k++) put(8'($urandom_range(0, 255)), 1'b0, 1'b1, 3'(k));
    put(8'hff, 1'b0, 1'b0, KIND_BUILD);
    // extreme bytes, mixed case, keyword completed on the end request
    put(8'hff, 1'b1, 1'b0, KIND_OTHER);
    put(8'h00, 1'b1, 1'b0, KIND_OTHER);
    put("D", 1'b1, 1'b0, KIND_OTHER);
    put("n", 1'b1, 1'b0, KIND_OTHER);
    put("S", 1'b1, 1'b1, KIND_TEST);
    // longest keyword fills the whole window and outranks the syntax keyword inside it
    caps = "INVALID RESOURCE";
    for (int i = 0; i < caps.len(); i++) put(caps[i], 1'b1, i == caps.len() - 1, KIND_LINT);

    n_planned = 0;
    hold_next = 1'b1;
    while (n_planned < RANDOM_REQS) begin
      if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
      if ($urandom_range(0, 19) == 0) hold_next = 1'b1;
      txt.delete();
      style = $urandom_range(0, 9);
      if (style == 0) begin
        repeat ($urandom_range(0, 24)) txt.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 3)) begin
          repeat ($urandom_range(0, 5)) txt.push_back(pick_filler());
          word = kw_text[$urandom_range(0, KEY_COUNT - 1)];
          bad = (style == 1 && $urandom_range(0, 1)) ? $urandom_range(0, word.len() - 1) : -1;
          cut = (style == 1 && bad < 0) ? word.len() - 1 : word.len();
          for (int i = 0; i < cut; i++) begin
            ch = (i == bad) ? 8'($urandom_range(97, 122)) : word[i];
            if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
            txt.push_back(ch);
          end
        end
        repeat ($urandom_range(0, 3)) txt.push_back(pick_filler());
      end
      kind = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      tail = txt.size() > 0 && $urandom_range(0, 1);
      foreach (txt[i]) begin
        if ($urandom_range(0, 9) == 0)
          put(8'($urandom_range(0, 255)), 1'b0, 1'b0, 3'($urandom_range(0, 7)));
        if (tail && i == txt.size() - 1) put(txt[i], 1'b1, 1'b1, kind);
        else put(txt[i], 1'b1, 1'b0, 3'($urandom_range(0, 7)));
      end
      if (!tail) put(8'($urandom_range(0, 255)), 1'b0, 1'b1, kind);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pend.size() != 0 || s_axis_tvalid || category_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (category_q.size() != 0) begin
      n_err += category_q.size();
      $display("error: %0d categories never arrived", category_q.size());
    end
    $display("covered %0d requests and %0d messages, categories seen %b", n_req, n_msg,
             cat_seen);
    $display("%0d mismatches", n_err);
    if (n_err == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    msg_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pend.size() != 0 && !(pend[0].hold && category_q.size() != 0)) begin
        nxt = pend.pop_front();
        s_axis_tdata <= nxt.data;
        s_axis_tuser <= {nxt.kind, nxt.present};
        s_axis_tlast <= nxt.last;
        s_axis_tvalid <= 1'b1;
        tx_gap <= nxt.gap;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 11) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
      end
      if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    cat_t want;
    cat_t got;
    bit   gives;
    if (rst) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      out_taken <= m_axis_tvalid && m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = cat_t'(m_axis_tdata[2:0]);
        if (category_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("error: unexpected category %s (tdata %h)", got.name(),
                                    m_axis_tdata);
        end else begin
          want = category_q.pop_front();
          n_msg++;
          cat_seen[want] = 1'b1;
          if (m_axis_tdata !== {5'b0, want}) begin
            n_err++;
            if (n_err <= 10) $display("error: message %0d category expected %s (%h) got %h",
                                      n_msg, want.name(), {5'b0, want}, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n_req++;
        predict_category(s_axis_tdata, s_axis_tuser[0], s_axis_tlast, s_axis_tuser[3:1],
                         gives, want);
        if (gives) category_q.push_back(want);
      end
    end
  end

endmodule
